// ----- design/psa_pkg.sv -----
// Shared types and constants for the paged slot allocator.
// No dependencies; imported by every design file except psa_ram.
package psa_pkg;

  localparam int SLOT_W         = 12;
  localparam int SPP_W          = 9;
  localparam int DEF_MAX_PAGES  = 16;
  localparam int DEF_MAX_SPP    = 256;
  localparam int DEF_FREE_DEPTH = 64;

  localparam logic [SPP_W-1:0] SPP_RESET = 9'd256;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_DUP        = 2'd1,
    ST_NO_PAGE    = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } psa_result_t;

endpackage

// ----- design/psa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/psa_engine.sv -----
// Allocator sequencer: counters, free stack in psa_ram, duplicate scan.
// Depends on psa_pkg and psa_ram.
module psa_engine #(
  parameter int MAX_PAGES          = psa_pkg::DEF_MAX_PAGES,
  parameter int MAX_SLOTS_PER_PAGE = psa_pkg::DEF_MAX_SPP,
  parameter int FREE_DEPTH         = psa_pkg::DEF_FREE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         req_action,
  input  logic [psa_pkg::SLOT_W-1:0]   req_slot,
  input  logic [psa_pkg::SPP_W-1:0]    spp,
  output logic                         res_valid,
  input  logic                         res_ready,
  output psa_pkg::psa_result_t         res
);
  import psa_pkg::*;

  localparam int CW = $clog2(FREE_DEPTH + 1);
  localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam logic [SPP_W-1:0] MSPP   = SPP_W'(MAX_SLOTS_PER_PAGE);
  localparam logic [CW-1:0]    FDEPTH = CW'(FREE_DEPTH);
  localparam logic [PW-1:0]    MPAGES = PW'(MAX_PAGES);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_POP, S_SCAN, S_DECIDE, S_RESULT
  } state_t;

  state_t            state_r,    state_nxt;
  action_t           act_r,      act_nxt;
  logic [SLOT_W-1:0] slot_r,     slot_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [PW-1:0]     page_cnt_r, page_cnt_nxt;
  logic [SPP_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [CW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              found_r,    found_nxt;
  psa_result_t       res_r,      res_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;

  logic [SPP_W-1:0]  eff_spp;
  logic [CW-1:0]     fc_m1;
  logic              page_full;
  logic [PW-1:0]     page_use;
  logic [SPP_W-1:0]  fill_use;
  logic [SLOT_W-1:0] bump_slot, last_slot;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PW-1:0] page,
                                                 input logic [SPP_W-1:0] off);
    logic [31:0] base;
    base = 32'(page) * 32'(MAX_SLOTS_PER_PAGE);
    return base[SLOT_W-1:0] + SLOT_W'(off);
  endfunction

  psa_ram #(.WIDTH(SLOT_W), .DEPTH(FREE_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (spp == '0) begin
      eff_spp = SPP_W'(1);
    end else if (spp > MSPP) begin
      eff_spp = MSPP;
    end else begin
      eff_spp = spp;
    end
    fc_m1     = free_cnt_r - CW'(1);
    page_full = (fill_cnt_r >= eff_spp);
    page_use  = page_full ? page_cnt_r + PW'(1) : page_cnt_r;
    fill_use  = page_full ? '0 : fill_cnt_r;
    bump_slot = slot_of(page_use - PW'(1), fill_use);
    last_slot = slot_of(page_cnt_r - PW'(1), fill_cnt_r - SPP_W'(1));
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    slot_nxt     = slot_r;
    free_cnt_nxt = free_cnt_r;
    page_cnt_nxt = page_cnt_r;
    fill_cnt_nxt = fill_cnt_r;
    scan_idx_nxt = scan_idx_r;
    found_nxt    = found_r;
    res_nxt      = res_r;
    ram_re       = 1'b0;
    ram_raddr    = scan_idx_r[AW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = free_cnt_r[AW-1:0];
    ram_wdata    = slot_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          act_nxt   = action_t'(req_action);
          slot_nxt  = req_slot;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '{slot: '0, status: ST_DONE};
        found_nxt = 1'b0;
        if (act_r == ACT_ALLOC) begin
          if (free_cnt_r != '0) begin
            ram_re       = 1'b1;
            ram_raddr    = fc_m1[AW-1:0];
            free_cnt_nxt = fc_m1;
            state_nxt    = S_POP;
          end else if (page_full && page_cnt_r >= MPAGES) begin
            res_nxt.status = ST_NO_PAGE;
            state_nxt      = S_RESULT;
          end else begin
            res_nxt.slot = bump_slot;
            page_cnt_nxt = page_use;
            fill_cnt_nxt = fill_use + SPP_W'(1);
            state_nxt    = S_RESULT;
          end
        end else if (free_cnt_r != '0) begin
          ram_re       = 1'b1;
          ram_raddr    = '0;
          scan_idx_nxt = CW'(1);
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_POP: begin
        res_nxt.slot = ram_rdata;
        state_nxt    = S_RESULT;
      end
      S_SCAN: begin
        if (ram_rdata == slot_r) begin
          found_nxt = 1'b1;
        end
        if (scan_idx_r < free_cnt_r) begin
          ram_re       = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        if (found_r) begin
          res_nxt.status = ST_DUP;
        end else if (fill_cnt_r != '0 && slot_r == last_slot) begin
          if (fill_cnt_r == SPP_W'(1)) begin
            if (page_cnt_r > PW'(1)) begin
              page_cnt_nxt = page_cnt_r - PW'(1);
              fill_cnt_nxt = eff_spp;
            end else begin
              fill_cnt_nxt = '0;
            end
          end else begin
            fill_cnt_nxt = fill_cnt_r - SPP_W'(1);
          end
        end else if (free_cnt_r >= FDEPTH) begin
          res_nxt.status = ST_STACK_FULL;
        end else begin
          ram_we       = 1'b1;
          free_cnt_nxt = free_cnt_r + CW'(1);
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_cnt_r <= '0;
      page_cnt_r <= PW'(1);
      fill_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      page_cnt_r <= page_cnt_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
    act_r      <= act_nxt;
    slot_r     <= slot_nxt;
    scan_idx_r <= scan_idx_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

endmodule

// ----- design/paged_slot_allocator.sv -----
// Paged slot allocator top level; depends on psa_pkg and psa_engine.
// Steps from the accepting edge: an allocate from the current page passes EXEC and
// RESULT, a free-stack pop EXEC, POP and RESULT, and a release EXEC, a SCAN of the
// free-stack entries if any (one RAM read a cycle), DECIDE and RESULT.
// One request in work; the next is taken once its result has entered the output reg.
// Synchronous active-low reset: one page open, fill and free stack empty, spp 256.
module paged_slot_allocator #(
  parameter int MAX_PAGES          = psa_pkg::DEF_MAX_PAGES,
  parameter int MAX_SLOTS_PER_PAGE = psa_pkg::DEF_MAX_SPP,
  parameter int FREE_DEPTH         = psa_pkg::DEF_FREE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [psa_pkg::SLOT_W-1:0] in_slot_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [psa_pkg::SLOT_W-1:0] out_slot_out,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psa_pkg::SPP_W-1:0]  cfg_slots_per_page
);
  import psa_pkg::*;

  logic [SPP_W-1:0]  spp_r, spp_nxt;
  logic              out_valid_r, out_valid_nxt;
  psa_result_t       out_r, out_nxt;
  logic              res_valid, res_ready;
  psa_result_t       res;

  psa_engine #(
    .MAX_PAGES          (MAX_PAGES),
    .MAX_SLOTS_PER_PAGE (MAX_SLOTS_PER_PAGE),
    .FREE_DEPTH         (FREE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_action (in_action),
    .req_slot   (in_slot_in),
    .spp        (spp_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    spp_nxt       = cfg_valid ? cfg_slots_per_page : spp_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r       <= SPP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      spp_r       <= spp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_slot_out = out_r.slot;
  assign out_status   = out_r.status;

endmodule

// ----- design/psa_checker.sv -----
// Port-level checks for paged_slot_allocator, attached by bind.
// Depends on psa_pkg.
module psa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [psa_pkg::SLOT_W-1:0] out_slot_out,
  input logic [1:0]                 out_status
);
  import psa_pkg::*;

  logic [1:0] pending_r, pending_nxt;

  always_comb begin
    pending_nxt = pending_r;
    if (in_valid && in_ready) begin
      pending_nxt = pending_nxt + 2'd1;
    end
    if (out_valid && out_ready) begin
      pending_nxt = pending_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // every result belongs to an accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without request");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 2'd2 |-> !in_ready)
    else $error("request taken with result and work both held");

  // failures hand out no slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> out_slot_out == '0)
    else $error("slot on failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_slot_out) && $stable(out_status)))
    else $error("result changed while stalled");

endmodule

bind paged_slot_allocator psa_checker u_psa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_slot_out (out_slot_out),
  .out_status   (out_status)
);
